@@ design/pdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants of the pH dosing controller: item kinds,
// register indexes, register reset values and the front-to-back queue shape.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // Item kind, classified by the front
  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // Configuration register indexes
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t CFG_CONTROL_ENABLE = 3'd0;
  localparam cfg_index_t CFG_PH_MIN_MILLI   = 3'd1;
  localparam cfg_index_t CFG_PH_MAX_MILLI   = 3'd2;
  localparam cfg_index_t CFG_CALIB_OFFSET   = 3'd3;
  localparam cfg_index_t CFG_SLOPE_Q16      = 3'd4;
  localparam cfg_index_t CFG_PULSE_MS       = 3'd5;
  localparam cfg_index_t CFG_INTERVAL_MS    = 3'd6;

  // Register widths
  localparam int CFG_DATA_W  = 22;
  localparam int THRESH_W    = 14;
  localparam int OFFSET_W    = 15;
  localparam int SLOPE_W     = 22;
  localparam int PULSE_W     = 16;
  localparam int INTERVAL_W  = 20;
  localparam int PH_W        = 16;

  // Register reset values
  localparam logic [THRESH_W-1:0]   PH_MIN_RESET   = 14'd0;
  localparam logic [THRESH_W-1:0]   PH_MAX_RESET   = 14'd14000;
  localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 15'd24700;
  localparam logic [SLOPE_W-1:0]    SLOPE_RESET    = 22'd1825783;
  localparam logic [PULSE_W-1:0]    PULSE_RESET    = 16'd5000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd125000;

  // Q16 rounding: half of one unit before the shift
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;

  // Queue between front and back (power of two depth)
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // Configuration write request
  typedef struct packed {
    logic                  write;
    cfg_index_t            index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

  // Head of the item queue
  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

endpackage

@@ design/pdc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_front
// Accepts input requests, classifies each as tick or sample and holds them
// in a short queue until the back takes them.
// ----------------------------------------------------------------------------
module pdc_front import pdc_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                func,
  input  logic [ADC_BITS-1:0] sample_value,
  output queue_head_t         head,
  output logic [ADC_BITS-1:0] head_sample,
  input  logic                pop
);

  logic [ADC_BITS-1:0] q_sample [QUEUE_DEPTH];
  op_t                 q_op     [QUEUE_DEPTH];
  logic [QA_W-1:0]     wr_ptr;
  logic [QA_W-1:0]     rd_ptr;
  logic [QC_W-1:0]     count;
  logic                push;
  op_t                 op_in;

  // Classify the incoming request
  assign op_in = func ? OP_SAMPLE : OP_TICK;

  // Stall while the queue is full
  assign item_stall = (count == QC_W'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;

  // Present the oldest request
  assign head.valid  = (count != '0);
  assign head.op     = q_op[rd_ptr];
  assign head_sample = q_sample[rd_ptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]     <= op_in;
      q_sample[wr_ptr] <= sample_value;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      count <= count + QC_W'(push) - QC_W'(pop);
    end
  end

endmodule

@@ design/pdc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_back
// Carries out queued requests: pulse and interval timing on ticks, sample
// collection, and on the closing sample a sort, trimmed sum, division,
// conversion to milli-pH and the dosing decision. Holds the configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module pdc_back import pdc_pkg::*; #(
  parameter int SAMPLE_COUNT = 10,
  parameter int TRIM_COUNT   = 2,
  parameter int ADC_BITS     = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_req_t               cfg,
  input  queue_head_t            head,
  input  logic [ADC_BITS-1:0]    head_sample,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   pump_raise,
  output logic                   pump_lower,
  output logic                   sample_request,
  output logic                   ph_valid,
  output logic signed [PH_W-1:0] ph_milli
);

  // Trim limited so at least one sample is kept
  localparam int TRIM_MAX = (SAMPLE_COUNT - 1) / 2;
  localparam int TRIM_EFF = (TRIM_COUNT > TRIM_MAX) ? TRIM_MAX : TRIM_COUNT;
  localparam int KEEP     = SAMPLE_COUNT - 2 * TRIM_EFF;
  localparam int CNT_W    = $clog2(SAMPLE_COUNT);
  localparam int SUM_W    = ADC_BITS + $clog2(SAMPLE_COUNT + 1);
  localparam int STEP_W   = $clog2(SAMPLE_COUNT);
  localparam int PROD_W   = SLOPE_W + ADC_BITS;
  localparam int D_W      = PROD_W - FRAC_BITS;
  localparam int DIFF_W   = D_W + 2;

  // Reciprocal of the kept count, exact floor division for any sum
  localparam int     RECIP_SHIFT = SUM_W + $clog2(KEEP);
  localparam longint RECIP       =
    ((longint'(1) << RECIP_SHIFT) + longint'(KEEP) - longint'(1)) / longint'(KEEP);
  localparam int     RECIP_W     = RECIP_SHIFT + 1;
  localparam int     QPROD_W     = SUM_W + RECIP_W;

  typedef enum logic [7:0] {
    ST_RUN   = 8'b0000_0001,
    ST_SORT  = 8'b0000_0010,
    ST_SUM   = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_ROUND = 8'b0010_0000,
    ST_SAT   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  // Configuration registers
  logic                  control_enable;
  logic [THRESH_W-1:0]   ph_min_milli;
  logic [THRESH_W-1:0]   ph_max_milli;
  logic [OFFSET_W-1:0]   calib_offset_milli;
  logic [SLOPE_W-1:0]    slope_q16;
  logic [PULSE_W-1:0]    pulse_ms;
  logic [INTERVAL_W-1:0] interval_ms;

  // Control state
  state_t                state, state_next;
  logic [INTERVAL_W-1:0] interval_count, interval_count_next;
  logic [PULSE_W-1:0]    raise_timer, raise_timer_next;
  logic [PULSE_W-1:0]    lower_timer, lower_timer_next;
  logic                  raise_busy, raise_busy_next;
  logic                  lower_busy, lower_busy_next;
  logic                  raise_level, raise_level_next;
  logic                  lower_level, lower_level_next;
  logic                  collecting, collecting_next;
  logic [CNT_W-1:0]      sample_count, sample_count_next;
  logic [STEP_W-1:0]     step, step_next;

  // Datapath registers
  logic [ADC_BITS-1:0]   line        [SAMPLE_COUNT];
  logic [ADC_BITS-1:0]   line_next   [SAMPLE_COUNT];
  logic [ADC_BITS-1:0]   line_sorted [SAMPLE_COUNT];
  logic [SUM_W-1:0]      sum, sum_next;
  logic [SUM_W-1:0]      quot, quot_next;
  logic [PROD_W-1:0]     prod, prod_next;
  logic [D_W-1:0]        dval, dval_next;
  logic signed [PH_W-1:0] ph, ph_next;

  // Result staging
  logic                  out_free;
  logic                  out_load;
  logic                  out_ph_valid;
  logic signed [PH_W-1:0] out_ph;

  // Combinational helpers
  logic [PULSE_W-1:0]    rt_inc;
  logic [PULSE_W-1:0]    lt_inc;
  logic [INTERVAL_W-1:0] ic_inc;
  logic [QPROD_W-1:0]    qprod;
  logic [DIFF_W-1:0]     diff;
  logic [DIFF_W-16:0]    diff_hi;
  logic                  phase;

  assign out_free = !result_valid || !result_stall;
  assign rt_inc   = raise_timer + PULSE_W'(raise_timer != '1);
  assign lt_inc   = lower_timer + PULSE_W'(lower_timer != '1);
  assign ic_inc   = interval_count + INTERVAL_W'(1);
  assign qprod    = QPROD_W'(sum) * QPROD_W'(RECIP);
  assign diff     = DIFF_W'(calib_offset_milli) - DIFF_W'(dval);
  assign diff_hi  = diff[DIFF_W-1:PH_W-1];
  assign phase    = step[0];

  // One odd-even transposition pass over disjoint neighbor pairs
  always_comb begin
    line_sorted = line;
    for (int i = 0; i < SAMPLE_COUNT - 1; i++) begin
      if ((1'(i) == phase) && (line[i] > line[i+1])) begin
        line_sorted[i]   = line[i+1];
        line_sorted[i+1] = line[i];
      end
    end
  end

  // Sequence requests and the measurement
  always_comb begin
    state_next          = state;
    interval_count_next = interval_count;
    raise_timer_next    = raise_timer;
    lower_timer_next    = lower_timer;
    raise_busy_next     = raise_busy;
    lower_busy_next     = lower_busy;
    raise_level_next    = raise_level;
    lower_level_next    = lower_level;
    collecting_next     = collecting;
    sample_count_next   = sample_count;
    step_next           = step;
    line_next           = line;
    sum_next            = sum;
    quot_next           = quot;
    prod_next           = prod;
    dval_next           = dval;
    ph_next             = ph;
    pop                 = 1'b0;
    out_load            = 1'b0;
    out_ph_valid        = 1'b0;
    out_ph              = '0;

    case (state)
      ST_RUN: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          if (head.op == OP_TICK) begin
            out_load = 1'b1;
            if (raise_busy) begin
              raise_timer_next = rt_inc;
              if (rt_inc >= pulse_ms) begin
                raise_level_next = 1'b0;
                raise_busy_next  = 1'b0;
              end
            end
            if (lower_busy) begin
              lower_timer_next = lt_inc;
              if (lt_inc >= pulse_ms) begin
                lower_level_next = 1'b0;
                lower_busy_next  = 1'b0;
              end
            end
            if (ic_inc >= interval_ms) begin
              interval_count_next = '0;
              if (control_enable && !collecting) begin
                collecting_next   = 1'b1;
                sample_count_next = '0;
              end
            end else begin
              interval_count_next = ic_inc;
            end
          end else if (collecting) begin
            // Shift the sample into the line; order is restored by the sort
            for (int i = 0; i < SAMPLE_COUNT - 1; i++) begin
              line_next[i] = line[i+1];
            end
            line_next[SAMPLE_COUNT-1] = head_sample;
            if (sample_count == CNT_W'(SAMPLE_COUNT - 1)) begin
              collecting_next   = 1'b0;
              sample_count_next = '0;
              step_next         = '0;
              state_next        = ST_SORT;
            end else begin
              sample_count_next = sample_count + CNT_W'(1);
              out_load          = 1'b1;
            end
          end else begin
            out_load = 1'b1;
          end
        end
      end

      ST_SORT: begin
        line_next = line_sorted;
        if (step == STEP_W'(SAMPLE_COUNT - 1)) begin
          step_next  = '0;
          sum_next   = '0;
          state_next = ST_SUM;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end

      ST_SUM: begin
        // Rotate the sorted line past tap zero; add the kept middle
        for (int i = 0; i < SAMPLE_COUNT - 1; i++) begin
          line_next[i] = line[i+1];
        end
        line_next[SAMPLE_COUNT-1] = line[0];
        if ((step >= STEP_W'(TRIM_EFF)) &&
            (step <= STEP_W'(SAMPLE_COUNT - 1 - TRIM_EFF))) begin
          sum_next = sum + SUM_W'(line[0]);
        end
        if (step == STEP_W'(SAMPLE_COUNT - 1)) begin
          step_next  = '0;
          state_next = ST_DIV;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end

      ST_DIV: begin
        // Divide by the kept count through the reciprocal product
        quot_next  = SUM_W'(qprod >> RECIP_SHIFT);
        state_next = ST_MUL;
      end

      ST_MUL: begin
        prod_next  = PROD_W'(slope_q16) * PROD_W'(quot[ADC_BITS-1:0]);
        state_next = ST_ROUND;
      end

      ST_ROUND: begin
        dval_next  = D_W'((prod + PROD_W'(ROUND_HALF)) >> FRAC_BITS);
        state_next = ST_SAT;
      end

      ST_SAT: begin
        // Saturate the signed difference to 16 bits
        if ((&diff_hi) || !(|diff_hi)) begin
          ph_next = diff[PH_W-1:0];
        end else if (diff[DIFF_W-1]) begin
          ph_next = {1'b1, {(PH_W-1){1'b0}}};
        end else begin
          ph_next = {1'b0, {(PH_W-1){1'b1}}};
        end
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_ph_valid = 1'b1;
          out_ph       = ph;
          state_next   = ST_RUN;
          if (control_enable) begin
            if ((ph < $signed({2'b00, ph_min_milli})) && !raise_busy) begin
              raise_level_next = 1'b1;
              lower_level_next = 1'b0;
              raise_busy_next  = 1'b1;
              raise_timer_next = '0;
            end else if ((ph > $signed({2'b00, ph_max_milli})) && !lower_busy) begin
              lower_level_next = 1'b1;
              raise_level_next = 1'b0;
              lower_busy_next  = 1'b1;
              lower_timer_next = '0;
            end
          end
        end
      end

      default: begin
        state_next = ST_RUN;
      end
    endcase

    // Disabling control drops pulses and any sample collection in progress
    if (cfg.write && (cfg.index == CFG_CONTROL_ENABLE) && !cfg.data[0]) begin
      raise_level_next  = 1'b0;
      lower_level_next  = 1'b0;
      raise_busy_next   = 1'b0;
      lower_busy_next   = 1'b0;
      raise_timer_next  = '0;
      lower_timer_next  = '0;
      collecting_next   = 1'b0;
      sample_count_next = '0;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      control_enable     <= 1'b0;
      ph_min_milli       <= PH_MIN_RESET;
      ph_max_milli       <= PH_MAX_RESET;
      calib_offset_milli <= OFFSET_RESET;
      slope_q16          <= SLOPE_RESET;
      pulse_ms           <= PULSE_RESET;
      interval_ms        <= INTERVAL_RESET;
    end else if (cfg.write) begin
      case (cfg.index)
        CFG_CONTROL_ENABLE: control_enable     <= cfg.data[0];
        CFG_PH_MIN_MILLI:   ph_min_milli       <= cfg.data[THRESH_W-1:0];
        CFG_PH_MAX_MILLI:   ph_max_milli       <= cfg.data[THRESH_W-1:0];
        CFG_CALIB_OFFSET:   calib_offset_milli <= cfg.data[OFFSET_W-1:0];
        CFG_SLOPE_Q16:      slope_q16          <= cfg.data[SLOPE_W-1:0];
        CFG_PULSE_MS:       pulse_ms           <= cfg.data[PULSE_W-1:0];
        CFG_INTERVAL_MS:    interval_ms        <= cfg.data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RUN;
      interval_count <= '0;
      raise_timer    <= '0;
      lower_timer    <= '0;
      raise_busy     <= 1'b0;
      lower_busy     <= 1'b0;
      raise_level    <= 1'b0;
      lower_level    <= 1'b0;
      collecting     <= 1'b0;
      sample_count   <= '0;
      step           <= '0;
      result_valid   <= 1'b0;
    end else begin
      state          <= state_next;
      interval_count <= interval_count_next;
      raise_timer    <= raise_timer_next;
      lower_timer    <= lower_timer_next;
      raise_busy     <= raise_busy_next;
      lower_busy     <= lower_busy_next;
      raise_level    <= raise_level_next;
      lower_level    <= lower_level_next;
      collecting     <= collecting_next;
      sample_count   <= sample_count_next;
      step           <= step_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold datapath and result payload
  always_ff @(posedge clk) begin
    line <= line_next;
    sum  <= sum_next;
    quot <= quot_next;
    prod <= prod_next;
    dval <= dval_next;
    ph   <= ph_next;
    if (out_load) begin
      pump_raise     <= raise_level_next;
      pump_lower     <= lower_level_next;
      sample_request <= collecting_next;
      ph_valid       <= out_ph_valid;
      ph_milli       <= out_ph;
    end
  end

endmodule

@@ design/ph_dosing_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ph_dosing_controller
// Bang-bang pH dosing controller with trimmed-mean measurement. Ticks time
// the pump pulses and the measurement interval; samples fill the set that
// is sorted, trimmed and averaged into milli-pH.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------------
//  item     | item_valid / item_stall| func, sample_value
//  result   | result_valid/result_st.| pump_raise, pump_lower, sample_request,
//           |                        | ph_valid, ph_milli
//  config   | cfg_write              | cfg_index, cfg_data
//
//  A tick or a non-closing sample is written into the four-entry queue;
//  once it is at the head, the back pops it into the result register.
//  In the back the closing sample passes through its pop, a sort pass and
//  a sum step per sample, then divide by reciprocal multiply, multiply by
//  slope, round, saturate and decide.
//  Reset is synchronous and clears all control state and the registers to
//  their reset values; the sample line holds no reset.
//  A stalled result holds; the back waits on it and the queue fills behind.
// ----------------------------------------------------------------------------
module ph_dosing_controller import pdc_pkg::*; #(
  parameter int SAMPLE_COUNT = 10,
  parameter int TRIM_COUNT   = 2,
  parameter int ADC_BITS     = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   func,
  input  logic [ADC_BITS-1:0]    sample_value,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   pump_raise,
  output logic                   pump_lower,
  output logic                   sample_request,
  output logic                   ph_valid,
  output logic signed [PH_W-1:0] ph_milli,
  input  logic                   cfg_write,
  input  cfg_index_t             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  queue_head_t         head;
  logic [ADC_BITS-1:0] head_sample;
  logic                pop;
  cfg_req_t            cfg;

  // Bundle the configuration write
  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  pdc_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .sample_value (sample_value),
    .head         (head),
    .head_sample  (head_sample),
    .pop          (pop)
  );

  pdc_back #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .TRIM_COUNT   (TRIM_COUNT),
    .ADC_BITS     (ADC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head           (head),
    .head_sample    (head_sample),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .pump_raise     (pump_raise),
    .pump_lower     (pump_lower),
    .sample_request (sample_request),
    .ph_valid       (ph_valid),
    .ph_milli       (ph_milli)
  );

endmodule

@@ design/pdc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks of the pH dosing controller, bound to the top level.
// ----------------------------------------------------------------------------
module pdc_checker import pdc_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input logic                   func,
  input logic [ADC_BITS-1:0]    sample_value,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic                   pump_raise,
  input logic                   pump_lower,
  input logic                   sample_request,
  input logic                   ph_valid,
  input logic signed [PH_W-1:0] ph_milli,
  input logic                   cfg_write,
  input cfg_index_t             cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  // Never drive both pumps at once
  a_pumps_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(pump_raise && pump_lower))
    else $error("both pumps driven");

  // A finished measurement no longer requests samples
  a_done_no_request: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ph_valid) |-> !sample_request)
    else $error("sample request with finished measurement");

  // Results without a measurement carry zero pH
  a_ph_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !ph_valid) |-> (ph_milli == '0))
    else $error("nonzero pH without measurement");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(ph_milli) && $stable(ph_valid) &&
       $stable(pump_raise) && $stable(pump_lower)))
    else $error("stalled result changed");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result present after reset");

endmodule

bind ph_dosing_controller pdc_checker #(.ADC_BITS(ADC_BITS)) u_pdc_checker (.*);
